// ===== rtl/core/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

  localparam int EW   = 32;          // element width, Q16.16
  localparam int CW   = 64;          // cofactor width, Q32.32
  localparam int PW   = 97;          // signed determinant width, Q48.48
  localparam int MW   = PW - 1;      // determinant magnitude
  localparam int QB   = EW + 1;      // quotient bits worked out per lane
  localparam int NW   = MW + 2;      // dividend width: cm * 2^QB + dmag
  localparam int DNW  = MW + 1;      // divisor width: 2 * dmag
  localparam int NELEM = 9;
  localparam int LANE_LAT = QB + 1;  // overflow check plus one stage per bit

  localparam logic [QB-1:0] Q_POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0] Q_NEG_LIM = 33'h0_8000_0000;
  localparam logic [EW-1:0] R_MAX     = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] R_MIN     = 32'h8000_0000;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;

  typedef struct packed {
    logic signed [EW-1:0] m00;
    logic signed [EW-1:0] m01;
    logic signed [EW-1:0] m02;
    logic signed [EW-1:0] m10;
    logic signed [EW-1:0] m11;
    logic signed [EW-1:0] m12;
    logic signed [EW-1:0] m20;
    logic signed [EW-1:0] m21;
    logic signed [EW-1:0] m22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [EW-1:0] r00;
    logic signed [EW-1:0] r01;
    logic signed [EW-1:0] r02;
    logic signed [EW-1:0] r10;
    logic signed [EW-1:0] r11;
    logic signed [EW-1:0] r12;
    logic signed [EW-1:0] r20;
    logic signed [EW-1:0] r21;
    logic signed [EW-1:0] r22;
    logic                 singular;
    logic                 saturated;
  } mi3_out_t;

  typedef struct packed {
    logic [NW-1:0]  num;
    logic [DNW-1:0] den;
    logic           neg;
    logic           zero;
  } mi3_lane_in_t;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          ovf;
    logic          neg;
    logic          zero;
  } mi3_lane_out_t;

  // {sat, value}: sign applied, clipped to 32 bits
  function automatic logic [EW:0] fmt_elem(logic [QB-1:0] q, logic ovf, logic neg);
    logic [EW:0]   res;
    logic [QB-1:0] nq;
    nq = ~q + {{(QB-1){1'b0}}, 1'b1};
    if (neg) begin
      if (ovf || (q > Q_NEG_LIM)) res = {1'b1, R_MIN};
      else res = {1'b0, nq[EW-1:0]};
    end else begin
      if (ovf || (q > Q_POS_LIM)) res = {1'b1, R_MAX};
      else res = {1'b0, q[EW-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mi3_cofactor.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mi3_cofactor (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  vld_i,
  input  mi3_pkg::mi3_in_t     data_i,
  output logic                 vld_o,
  output mi3_pkg::cof_t        adj_o [mi3_pkg::NELEM],
  output mi3_pkg::elem_t       row0_o [3]
);

  mi3_pkg::cof_t  pp_r   [2*mi3_pkg::NELEM];
  mi3_pkg::cof_t  pp_nxt [2*mi3_pkg::NELEM];
  mi3_pkg::elem_t r0a_r  [3];
  mi3_pkg::elem_t r0b_r  [3];
  mi3_pkg::cof_t  adj_r  [mi3_pkg::NELEM];
  logic [1:0]     vld_r;

  mi3_pkg::elem_t a, b, c, d, e, f, g, h, i;

  always_comb begin
    a = data_i.m00; b = data_i.m01; c = data_i.m02;
    d = data_i.m10; e = data_i.m11; f = data_i.m12;
    g = data_i.m20; h = data_i.m21; i = data_i.m22;
    // pairs (plus, minus) per adjugate entry, row-major
    pp_nxt[0]  = e * i; pp_nxt[1]  = f * h;
    pp_nxt[2]  = c * h; pp_nxt[3]  = b * i;
    pp_nxt[4]  = b * f; pp_nxt[5]  = c * e;
    pp_nxt[6]  = f * g; pp_nxt[7]  = d * i;
    pp_nxt[8]  = a * i; pp_nxt[9]  = c * g;
    pp_nxt[10] = c * d; pp_nxt[11] = a * f;
    pp_nxt[12] = d * h; pp_nxt[13] = e * g;
    pp_nxt[14] = b * g; pp_nxt[15] = a * h;
    pp_nxt[16] = a * e; pp_nxt[17] = b * d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2*mi3_pkg::NELEM; k++) pp_r[k] <= pp_nxt[k];
      r0a_r[0] <= a; r0a_r[1] <= b; r0a_r[2] <= c;
      for (int k = 0; k < 3; k++) r0b_r[k] <= r0a_r[k];
      // exact: each difference stays inside 64 bits
      for (int k = 0; k < mi3_pkg::NELEM; k++) adj_r[k] <= pp_r[2*k] - pp_r[2*k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  assign vld_o = vld_r[1];
  always_comb begin
    for (int k = 0; k < mi3_pkg::NELEM; k++) adj_o[k] = adj_r[k];
    for (int k = 0; k < 3; k++) row0_o[k] = r0b_r[k];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mi3_det.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mi3_det (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   vld_i,
  input  mi3_pkg::cof_t         adj_i [mi3_pkg::NELEM],
  input  mi3_pkg::elem_t        row0_i [3],
  output logic                  vld_o,
  output mi3_pkg::mi3_lane_in_t lane_o [mi3_pkg::NELEM]
);

  localparam int NE = mi3_pkg::NELEM;
  localparam int PW = mi3_pkg::PW;
  localparam int MW = mi3_pkg::MW;
  localparam int CW = mi3_pkg::CW;
  localparam int EW = mi3_pkg::EW;
  localparam int QB = mi3_pkg::QB;

  // adjugate delay line, one tap per stage
  mi3_pkg::cof_t        adj_r [4][NE];
  logic signed [EW+32:0] pl_r [3];   // x * low word (unsigned)
  logic signed [CW-1:0] ph_r [3];    // x * high word (signed)
  logic [PW-1:0]        pr_r [3];
  logic [PW-1:0]        s01_r, p2_r, det_r;
  logic [PW-1:0]        det_neg;
  logic [MW-1:0]        dmag_r;
  logic                 dneg_r, zero_r;
  logic [CW-1:0]        cm_r [NE];
  logic                 cneg_r [NE];
  mi3_pkg::mi3_lane_in_t lane_r [NE];
  logic [5:0]           vld_r;

  assign det_neg = ~det_r + {{(PW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        adj_r[0][k] <= adj_i[k];
        for (int s = 1; s < 4; s++) adj_r[s][k] <= adj_r[s-1][k];
      end
      // row 0 expansion: a*C00 + b*C01 + c*C02 (adj entries 0, 3, 6)
      for (int k = 0; k < 3; k++) begin
        pl_r[k] <= row0_i[k] * $signed({1'b0, adj_i[3*k][31:0]});
        ph_r[k] <= row0_i[k] * $signed(adj_i[3*k][CW-1:32]);
        pr_r[k] <= {ph_r[k][CW-1], ph_r[k], 32'd0} +
                   {{(PW-EW-33){pl_r[k][EW+32]}}, pl_r[k]};
      end
      s01_r  <= pr_r[0] + pr_r[1];
      p2_r   <= pr_r[2];
      det_r  <= s01_r + p2_r;
      dneg_r <= det_r[PW-1];
      zero_r <= (det_r == '0);
      dmag_r <= det_r[PW-1] ? det_neg[MW-1:0] : det_r[MW-1:0];
      for (int k = 0; k < NE; k++) begin
        cneg_r[k] <= adj_r[3][k][CW-1];
        cm_r[k]   <= adj_r[3][k][CW-1] ? (~adj_r[3][k] + {{(CW-1){1'b0}}, 1'b1})
                                       : adj_r[3][k];
        // round half away: (2*cm*2^32 + dmag) / (2*dmag)
        lane_r[k].num  <= {1'b0, cm_r[k], {QB{1'b0}}} + {2'b00, dmag_r};
        lane_r[k].den  <= {dmag_r, 1'b0};
        lane_r[k].neg  <= cneg_r[k] ^ dneg_r;
        lane_r[k].zero <= zero_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  assign vld_o = vld_r[5];
  always_comb begin
    for (int k = 0; k < NE; k++) lane_o[k] = lane_r[k];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mi3_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mi3_div_lane (
  input  wire                    clk,
  input  wire                    en,
  input  mi3_pkg::mi3_lane_in_t  lane_i,
  output mi3_pkg::mi3_lane_out_t lane_o
);

  localparam int QB  = mi3_pkg::QB;
  localparam int NW  = mi3_pkg::NW;
  localparam int DNW = mi3_pkg::DNW;
  localparam int HW  = NW - QB;       // dividend bits above the quotient window

  logic [DNW-1:0] rem_r  [QB+1];
  logic [QB-1:0]  low_r  [QB+1];
  logic [QB-1:0]  q_r    [QB+1];
  logic [DNW-1:0] den_r  [QB+1];
  logic           ovf_r  [QB+1];
  logic           neg_r  [QB+1];
  logic           zero_r [QB+1];

  logic [DNW-1:0] hi_ext;
  logic           ovf0;
  logic [DNW:0]   sh   [QB];
  logic           ge   [QB];
  logic [DNW:0]   diff [QB];

  assign hi_ext = {{(DNW-HW){1'b0}}, lane_i.num[NW-1:QB]};
  assign ovf0   = (hi_ext >= lane_i.den);

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      sh[k]   = {rem_r[k], low_r[k][QB-1]};
      ge[k]   = (sh[k] >= {1'b0, den_r[k]});
      diff[k] = sh[k] - {1'b0, den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ovf0 ? '0 : hi_ext;
      low_r[0]  <= lane_i.num[QB-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= lane_i.den;
      ovf_r[0]  <= ovf0;
      neg_r[0]  <= lane_i.neg;
      zero_r[0] <= lane_i.zero;
      // restoring division, one quotient bit per stage
      for (int k = 0; k < QB; k++) begin
        rem_r[k+1]  <= ge[k] ? diff[k][DNW-1:0] : sh[k][DNW-1:0];
        low_r[k+1]  <= {low_r[k][QB-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QB-2:0], ge[k]};
        den_r[k+1]  <= den_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  always_comb begin
    lane_o.q    = q_r[QB];
    lane_o.ovf  = ovf_r[QB];
    lane_o.neg  = neg_r[QB];
    lane_o.zero = zero_r[QB];
  end

endmodule

`default_nettype wire

// ===== rtl/core/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                              Beat
// in       in   in_valid, in_stall, in_data        one 3x3 matrix, nine Q16.16 elements
// out      out  out_valid, out_stall, out_data     inverse in Q16.16, singular, saturated
//
// One beat in and one beat out per cycle while out does not stall; from input to output:
// 2 cofactor stages, 6 determinant stages, 34 divider stages (overflow check
// plus one quotient bit per stage in nine parallel lanes) and the output register.
// Reset clears only the valid bits; payload registers are left as they are.
// A stall on a held out beat freezes all stages and raises in_stall in the same cycle.

module matrix_inverse_3x3 (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  mi3_pkg::mi3_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output mi3_pkg::mi3_out_t  out_data
);

  localparam int NE = mi3_pkg::NELEM;
  localparam int LL = mi3_pkg::LANE_LAT;
  localparam int EW = mi3_pkg::EW;

  logic                   en;
  logic                   cof_vld, det_vld;
  mi3_pkg::cof_t          adj [NE];
  mi3_pkg::elem_t         row0 [3];
  mi3_pkg::mi3_lane_in_t  lane_in  [NE];
  mi3_pkg::mi3_lane_out_t lane_out [NE];
  logic [LL-1:0]          div_vld_r;
  logic [EW:0]            res [NE];
  logic                   any_sat;
  logic                   out_valid_r;
  mi3_pkg::mi3_out_t      out_data_r, out_data_nxt;

  // whole pipeline advances unless a finished beat is held on out
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  mi3_cofactor u_cof (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .data_i (in_data),
    .vld_o  (cof_vld),
    .adj_o  (adj),
    .row0_o (row0)
  );

  mi3_det u_det (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cof_vld),
    .adj_i  (adj),
    .row0_i (row0),
    .vld_o  (det_vld),
    .lane_o (lane_in)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk    (clk),
      .en     (en),
      .lane_i (lane_in[k]),
      .lane_o (lane_out[k])
    );
  end

  // valid bits that track the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
    end else if (en) begin
      div_vld_r <= {div_vld_r[LL-2:0], det_vld};
    end
  end

  // sign, clipping and the singular case
  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < NE; k++) begin
      if (lane_out[k].zero) res[k] = '0;
      else res[k] = mi3_pkg::fmt_elem(lane_out[k].q, lane_out[k].ovf, lane_out[k].neg);
      any_sat = any_sat | res[k][EW];
    end
    out_data_nxt.r00       = res[0][EW-1:0];
    out_data_nxt.r01       = res[1][EW-1:0];
    out_data_nxt.r02       = res[2][EW-1:0];
    out_data_nxt.r10       = res[3][EW-1:0];
    out_data_nxt.r11       = res[4][EW-1:0];
    out_data_nxt.r12       = res[5][EW-1:0];
    out_data_nxt.r20       = res[6][EW-1:0];
    out_data_nxt.r21       = res[7][EW-1:0];
    out_data_nxt.r22       = res[8][EW-1:0];
    out_data_nxt.singular  = lane_out[0].zero;
    out_data_nxt.saturated = any_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_vld_r[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.singular |-> !out_data_r.saturated)
    else $error("singular beat flagged saturated");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.singular |->
      (out_data_r.r00 == '0) && (out_data_r.r11 == '0) && (out_data_r.r22 == '0))
    else $error("singular beat with nonzero diagonal");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("out_valid high after reset");

endmodule

`default_nettype wire
